// ===== sv/fbpa_pkg.sv =====
// Shared types and constants of the fixed block pool allocator.
`default_nettype none

package fbpa_pkg;

    localparam int GRP_W  = 8;
    localparam int GRP_SH = 3;
    localparam int CFG_W  = 7;
    localparam int SLOT_W = 6;

    typedef enum logic [1:0] {
        ST_GRANTED  = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_FREED    = 2'd2,
        ST_IGNORED  = 2'd3
    } t_status;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_op;

endpackage

`default_nettype wire

// ===== sv/fixed_block_pool_allocator_top.sv =====
// Fixed block pool allocator: rotating ring of bitmap cells and a request sequencer.
// The ring turns one 8-slot group a cycle past the head cell; it has NC = ceil(NUM_SLOTS/8) cells.
// Throughput: one request in flight; a new one is taken once the result is registered.
// Reset (synchronous, active low): all slots free, hint zero, pool size 64.
`default_nettype none

module fixed_block_pool_allocator_top #(
    parameter int NUM_SLOTS = 64
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire logic                        i_op,
    input  wire logic [fbpa_pkg::SLOT_W-1:0] i_slot,
    input  wire logic                        i_from_overflow,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output logic      [1:0]                  o_status,
    output logic      [fbpa_pkg::SLOT_W-1:0] o_granted_slot,
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic [fbpa_pkg::CFG_W-1:0]  i_cfg_data
);
    import fbpa_pkg::*;

    localparam int NC   = (NUM_SLOTS + GRP_W - 1) / GRP_W;
    localparam int GIW  = (NC > 1) ? $clog2(NC) : 1;
    localparam int SW   = $clog2(NUM_SLOTS);
    localparam int HW   = SW + 1;
    localparam int CW0  = (HW > CFG_W) ? HW : CFG_W;
    localparam int CW1  = (GIW + GRP_SH > SLOT_W + 1) ? GIW + GRP_SH : SLOT_W + 1;
    localparam int CW   = (CW0 > CW1) ? CW0 : CW1;

    typedef enum logic {
        S_IDLE,
        S_SEEK
    } t_state;

    t_state              r_state, n_state;
    logic                r_op;
    logic [SLOT_W-1:0]   r_slot;
    logic                r_ovf;
    logic [GIW-1:0]      r_tgt, n_tgt;
    logic [HW-1:0]       r_hint, n_hint;
    logic [GIW-1:0]      r_head_grp;
    logic [CFG_W-1:0]    r_pool;
    logic                r_out_valid;
    t_status             r_status;
    logic [SLOT_W-1:0]   r_granted;

    logic [GRP_W-1:0]    w_word [NC];
    logic [GRP_W-1:0]    w_head_new;
    logic                w_accept;
    logic                w_out_free;
    logic [CW-1:0]       w_limit;
    logic [CW-1:0]       w_pool_ext;
    logic [CW-1:0]       w_slot_ext;
    logic [CW-1:0]       w_hint_ext;
    logic [CW-1:0]       w_in_slot_ext;
    logic [CW-1:0]       w_base;
    logic [CW-1:0]       w_next_base;
    logic [CW-1:0]       w_pos;
    logic                w_at_head;
    logic                w_found;
    logic [GRP_SH-1:0]   w_fpos;
    logic [GRP_SH-1:0]   w_bit;
    logic                w_done;
    t_status             w_status;
    logic [CW-1:0]       w_gidx;

    // bitmap ring: head is cell 0, the head group returns at the tail
    for (genvar k = 0; k < NC; k++) begin : g_cell
        if (k == NC - 1) begin : g_tail
            fbpa_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_word  (w_head_new),
                .o_word  (w_word[k])
            );
        end else begin : g_body
            fbpa_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_word  (w_word[k+1]),
                .o_word  (w_word[k])
            );
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_out_free  = !r_out_valid || i_out_ready;

    assign w_pool_ext    = CW'(r_pool);
    assign w_limit       = (w_pool_ext > CW'(NUM_SLOTS)) ? CW'(NUM_SLOTS) : w_pool_ext;
    assign w_slot_ext    = CW'(r_slot);
    assign w_hint_ext    = CW'(r_hint);
    assign w_in_slot_ext = CW'(i_slot);
    assign w_base        = CW'({r_tgt, GRP_SH'(0)});
    assign w_next_base   = w_base + CW'(GRP_W);
    assign w_at_head     = (r_head_grp == r_tgt);
    assign w_bit         = r_slot[GRP_SH-1:0];

    // lowest free slot of the head group inside [hint, limit)
    always_comb begin
        w_found = 1'b0;
        w_fpos  = '0;
        w_pos   = '0;
        for (int p = GRP_W - 1; p >= 0; p--) begin
            w_pos = w_base + CW'(p);
            if (!w_word[0][p] && (w_pos >= w_hint_ext) && (w_pos < w_limit)) begin
                w_found = 1'b1;
                w_fpos  = GRP_SH'(p);
            end
        end
    end

    always_comb begin
        n_state    = r_state;
        n_tgt      = r_tgt;
        n_hint     = r_hint;
        w_done     = 1'b0;
        w_status   = ST_IGNORED;
        w_gidx     = '0;
        w_head_new = w_word[0];
        if (r_state == S_SEEK && w_out_free) begin
            if (r_op == OP_FREE) begin
                priority if (r_ovf) begin
                    w_done   = 1'b1;
                    w_status = ST_FREED;
                end else if (w_slot_ext >= CW'(NUM_SLOTS)) begin
                    w_done   = 1'b1;
                    w_status = ST_IGNORED;
                end else if (w_at_head) begin
                    w_done = 1'b1;
                    if (w_word[0][w_bit]) begin
                        w_head_new[w_bit] = 1'b0;
                        w_status          = ST_FREED;
                        if (w_hint_ext > w_slot_ext) begin
                            n_hint = HW'(w_slot_ext);
                        end
                    end else begin
                        w_status = ST_IGNORED;
                    end
                end else begin
                    n_tgt = r_tgt;
                end
            end else begin
                priority if (w_hint_ext >= w_limit) begin
                    w_done   = 1'b1;
                    w_status = ST_OVERFLOW;
                end else if (w_at_head) begin
                    priority if (w_found) begin
                        w_head_new[w_fpos] = 1'b1;
                        w_done             = 1'b1;
                        w_status           = ST_GRANTED;
                        w_gidx             = w_base + CW'(w_fpos);
                        n_hint             = HW'(w_gidx + CW'(1));
                    end else if (w_next_base >= w_limit) begin
                        w_done   = 1'b1;
                        w_status = ST_OVERFLOW;
                    end else begin
                        n_tgt = r_tgt + GIW'(1);
                    end
                end else begin
                    n_tgt = r_tgt;
                end
            end
            if (w_done) begin
                n_state = S_IDLE;
            end
        end else if (w_accept) begin
            n_state = S_SEEK;
            if (i_op == OP_FREE) begin
                n_tgt = w_in_slot_ext[GIW+GRP_SH-1:GRP_SH];
            end else begin
                n_tgt = w_hint_ext[GIW+GRP_SH-1:GRP_SH];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_hint      <= '0;
            r_head_grp  <= '0;
            r_pool      <= CFG_W'(64);
            r_out_valid <= 1'b0;
            r_tgt       <= '0;
        end else begin
            r_state <= n_state;
            r_hint  <= n_hint;
            r_tgt   <= n_tgt;
            if (r_head_grp == GIW'(NC - 1)) begin
                r_head_grp <= '0;
            end else begin
                r_head_grp <= r_head_grp + GIW'(1);
            end
            if (i_cfg_valid) begin
                r_pool <= i_cfg_data;
            end
            if (w_accept) begin
                r_op   <= i_op;
                r_slot <= i_slot;
                r_ovf  <= i_from_overflow;
            end
            if (w_done) begin
                r_out_valid <= 1'b1;
                r_status    <= w_status;
                r_granted   <= w_gidx[SLOT_W-1:0];
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_granted_slot = r_granted;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_in_ready)
        else $error("input taken while a request is in flight");

    a_hint_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CW'(r_hint) <= CW'(NUM_SLOTS))
        else $error("search hint beyond pool");

    a_grant_in_pool: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_done && w_status == ST_GRANTED) |-> (w_gidx < w_limit))
        else $error("granted slot outside active pool");

    a_no_idx_otherwise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status != ST_GRANTED) |-> (r_granted == '0))
        else $error("slot index on a non-grant result");

endmodule

`default_nettype wire

// ===== sv/fbpa_cell.sv =====
// One cell of the rotating bitmap ring: holds the used bits of one slot group.
`default_nettype none

module fbpa_cell (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic [fbpa_pkg::GRP_W-1:0] i_word,
    output logic      [fbpa_pkg::GRP_W-1:0] o_word
);
    import fbpa_pkg::*;

    logic [GRP_W-1:0] r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word <= '0;
        end else begin
            r_word <= i_word;
        end
    end

    assign o_word = r_word;

endmodule

`default_nettype wire
